@@ rtl/sli_pkg.sv @@
// Shared constants and types for the sorted list insert block.
package sli_pkg;

    localparam int SLI_DEPTH = 32;
    localparam int ENTRY_W   = 32;
    localparam int POS_W     = 5;
    localparam int FILL_W    = 6;

    // Per-cycle control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                      ins;
        logic                      rot;
        logic signed [ENTRY_W-1:0] value;
    } sli_ctrl_t;

endpackage

@@ rtl/sorted_list_insert_core.sv @@
// Top level of the sorted list insert block: cell chain plus run sequencer.
//
// Usage: the block holds an ascending list of signed 32-bit values, empty
// after reset. Each input transaction (in_valid/in_ready, field value) is
// inserted after every stored entry less than or equal to it, in the accept
// cycle itself. The block then emits the whole list as output transactions
// (out_valid/out_ready), smallest first: entry, position, last on the final
// entry, refused when the list was already full (the value is dropped and the
// unchanged list is emitted), and fill, the count after this insert.
// Timing: the insert happens in the accept cycle; then the chain of cells
// rotates once around the ring before the next input is taken. The first
// result is registered on the first rotation step after the insert. The
// rotation is what sets the rate: cell 0 is the only read port, and the
// ring must come full circle so every entry is back in place before the
// next insert.
// A stalled receiver holds the output register and freezes the rotation
// while results remain; the next input is taken as soon as the rotation ends,
// even with the final result still waiting. Reset empties the list at once.
module sorted_list_insert_core
    import sli_pkg::*;
#(
    parameter int DEPTH = SLI_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [ENTRY_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [ENTRY_W-1:0] entry,
    output logic [POS_W-1:0]          position,
    output logic                      last,
    output logic                      refused,
    output logic [FILL_W-1:0]         fill
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t                    state_reg;
    logic [CW-1:0]             fill_reg;      // entries held
    logic [CW-1:0]             cnt_reg;       // rotation step in this run
    logic                      refused_reg;   // run flag, set at accept
    logic                      out_valid_reg;
    logic signed [ENTRY_W-1:0] entry_reg;
    logic [POS_W-1:0]          pos_reg;
    logic                      last_reg;
    logic                      refused_out_reg;
    logic [FILL_W-1:0]         fill_out_reg;

    logic                      accept;
    logic                      full;
    logic                      emitting;
    logic                      out_free;
    logic                      out_load;
    logic                      rot;
    sli_ctrl_t                 ctrl;

    logic signed [ENTRY_W-1:0] cell_entry [DEPTH];
    logic                      cell_gt    [DEPTH];

    assign in_ready = state_reg == ST_IDLE;
    assign accept   = in_valid && in_ready;
    assign full     = fill_reg == CW'(DEPTH);
    assign emitting = cnt_reg < fill_reg;
    assign out_free = !out_valid_reg || out_ready;
    // Steps past the fill count move garbage cells only and never wait.
    assign rot      = (state_reg == ST_EMIT) && (!emitting || out_free);
    // Cell 0 goes to the output register on every emitting step.
    assign out_load = rot && emitting;

    assign ctrl.ins   = accept && !full;
    assign ctrl.rot   = rot;
    assign ctrl.value = value;

    // Chain of cells: left neighbor feeds inserts, right neighbor feeds rotation.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            sli_cell #(.IDX(i), .CW(CW)) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .fill        (fill_reg),
                .left_entry  (value),
                .left_gt     (1'b0),
                .right_entry (cell_entry[(i + 1) % DEPTH]),
                .entry       (cell_entry[i]),
                .gt          (cell_gt[i])
            );
        end
        else
        begin : g_body
            sli_cell #(.IDX(i), .CW(CW)) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .fill        (fill_reg),
                .left_entry  (cell_entry[i - 1]),
                .left_gt     (cell_gt[i - 1]),
                .right_entry (cell_entry[(i + 1) % DEPTH]),
                .entry       (cell_entry[i]),
                .gt          (cell_gt[i])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            cnt_reg         <= '0;
            refused_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_reg       <= '0;
            pos_reg         <= '0;
            last_reg        <= 1'b0;
            refused_out_reg <= 1'b0;
            fill_out_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        refused_reg <= full;
                        if (!full)
                            fill_reg <= fill_reg + 1'b1;
                        cnt_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (rot)
                    begin
                        if (emitting)
                        begin
                            entry_reg       <= cell_entry[0];
                            pos_reg         <= POS_W'(cnt_reg);
                            last_reg        <= cnt_reg == fill_reg - 1'b1;
                            refused_out_reg <= refused_reg;
                            fill_out_reg    <= FILL_W'(fill_reg);
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CW'(DEPTH - 1))
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign entry     = entry_reg;
    assign position  = pos_reg;
    assign last      = last_reg;
    assign refused   = refused_out_reg;
    assign fill      = fill_out_reg;

endmodule

@@ rtl/sli_cell.sv @@
// One storage cell of the sorted chain: insert shift and emit rotation.
module sli_cell
    import sli_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
)
(
    input  logic                      clk,
    input  sli_ctrl_t                 ctrl,
    input  logic [CW-1:0]             fill,
    input  logic signed [ENTRY_W-1:0] left_entry,
    input  logic                      left_gt,
    input  logic signed [ENTRY_W-1:0] right_entry,
    output logic signed [ENTRY_W-1:0] entry,
    output logic                      gt
);

    logic signed [ENTRY_W-1:0] entry_reg;
    logic signed [ENTRY_W-1:0] entry_next;
    logic                      occupied;
    logic                      at_fill;

    assign occupied = CW'(IDX) < fill;
    assign at_fill  = fill == CW'(IDX);
    assign gt       = occupied && ($signed(entry_reg) > $signed(ctrl.value));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (left_gt)
                entry_next = left_entry;      // shift up behind the new value
            else if (gt || at_fill)
                entry_next = ctrl.value;      // first slot past the upper bound
        end
        else if (ctrl.rot)
        begin
            entry_next = right_entry;         // ring rotates toward cell 0
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/sli_checker.sv @@
// Port-level assertions for the sorted list insert block, with its bind.
module sli_checker
    import sli_pkg::*;
#(
    parameter int DEPTH = SLI_DEPTH
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [ENTRY_W-1:0] entry,
    input logic [POS_W-1:0]          position,
    input logic                      last,
    input logic                      refused,
    input logic [FILL_W-1:0]         fill
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry) && $stable(position)
            && $stable(last) && $stable(refused) && $stable(fill))
        else $error("output transaction changed while stalled");

    // The final result sits at index fill - 1.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> position == POS_W'(fill - 1'b1))
        else $error("last flag at wrong position");

    // A refusal only happens on a full list.
    a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && refused |-> fill == FILL_W'(DEPTH))
        else $error("refusal with list not full");

    // An accepted value starts a run; no second input right after.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken during a run");

    // Mid-run results mean the run is still going.
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |-> !in_ready)
        else $error("input ready before run finished");

endmodule

bind sorted_list_insert_core sli_checker #(.DEPTH(DEPTH)) u_sli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .entry     (entry),
    .position  (position),
    .last      (last),
    .refused   (refused),
    .fill      (fill)
);
